// File: hdl/multi_button_debouncer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-button debouncer
// Implication checks on the rising edge of clk, masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCER_CORE_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBD_ASSERT_NOW(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication
`define MBD_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`else
`define MBD_ASSERT_NOW(label, lhs, rhs, msg)
`define MBD_ASSERT_NEXT(label, lhs, rhs, msg)
`endif

`endif

// File: hdl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Field widths, codes, reset values and lane types of the debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int OP_W    = 2;
  localparam int ID_W    = 3;
  localparam int PIN_W   = 7;
  localparam int TICKS_W = 16;
  localparam int MASK_W  = 7;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_POLL = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 1'b1;

  localparam logic [TICKS_W-1:0] TICKS_RESET  = 16'd250;
  localparam logic [MASK_W-1:0]  INVERT_RESET = 7'd63;

  // per-lane command for one accepted item
  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
    logic            hit;    // edge item names this lane
  } lane_cmd_t;

  // per-lane finding
  typedef struct packed {
    logic fire;   // stable level changed, report due
    logic level;  // current level after inversion
  } lane_rpt_t;

endpackage

// File: hdl/mbd_if.sv
// ----------------------------------------------------------------------------
// mbd channel interfaces
// Valid/ready channels for incoming items and outgoing reports.
// ----------------------------------------------------------------------------
interface mbd_cmd_if;
  import mbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ID_W-1:0]  button_id;
  logic [PIN_W-1:0] pin_levels;

  modport source (output valid, output operation, output button_id,
                  output pin_levels, input ready);
  modport sink   (input valid, input operation, input button_id,
                  input pin_levels, output ready);
endinterface

interface mbd_rpt_if;
  import mbd_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] report_button;
  logic            report_level;
  logic            last_report;

  modport source (output valid, output report_button, output report_level,
                  output last_report, input ready);
  modport sink   (input valid, input report_button, input report_level,
                  input last_report, output ready);
endinterface

// File: hdl/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane
// One button: lockout countdown, stable level and change detection.
// ----------------------------------------------------------------------------
module mbd_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mbd_pkg::lane_cmd_t     cmd,
  input  logic                   level,
  input  logic [COUNT_WIDTH-1:0] load_value,
  output mbd_pkg::lane_rpt_t     rpt
);
  import mbd_pkg::*;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic                   stable;
  logic                   fire;

  assign count_dec = count - COUNT_WIDTH'(1);

  always_comb begin
    count_next = count;
    fire       = 1'b0;
    unique case (cmd.op)
      OP_TICK: begin
        if (count != '0) begin
          count_next = count_dec;
          fire       = (count_dec == '0) && (level != stable);
        end
      end
      OP_EDGE: begin
        if (cmd.hit && (count == '0)) begin
          count_next = load_value;
          fire       = (level != stable);
        end
      end
      OP_POLL: fire = (level != stable);
      default: ;  // unused code: no effect
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      stable <= 1'b0;
    end else if (cmd.accept) begin
      count <= count_next;
      if (fire) stable <= level;
    end
  end

  assign rpt.fire  = cmd.accept && fire;
  assign rpt.level = level;

endmodule

// File: hdl/mbd_merge.sv
// ----------------------------------------------------------------------------
// mbd_merge
// Collects lane findings and sends them out one per cycle while out_ready is high, lowest first.
// ----------------------------------------------------------------------------
`include "multi_button_debouncer_core_assert.svh"

module mbd_merge #(
  parameter int NUM_BUTTONS = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  mbd_pkg::lane_rpt_t [NUM_BUTTONS-1:0]  rpt,
  output logic                                  busy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mbd_pkg::ID_W-1:0]              out_button,
  output logic                                  out_level,
  output logic                                  out_last
);
  import mbd_pkg::*;

  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [NUM_BUTTONS-1:0] mask;
  logic [NUM_BUTTONS-1:0] levels;
  logic [NUM_BUTTONS-1:0] fires;
  logic [NUM_BUTTONS-1:0] cur_levels;
  logic [IW-1:0]          idx;
  logic [31:0]            idx_wide;
  logic                   take;

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      fires[i]      = rpt[i].fire;
      cur_levels[i] = rpt[i].level;
    end
  end

  // lowest pending button
  always_comb begin
    idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (mask[i]) idx = IW'(i);
    end
  end

  assign idx_wide   = 32'(idx);
  assign take       = out_valid && out_ready;
  assign busy       = (mask != '0);
  assign out_valid  = busy;
  assign out_button = idx_wide[ID_W-1:0];
  assign out_level  = levels[idx];
  assign out_last   = ((mask & (mask - NUM_BUTTONS'(1))) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= fires;
    end else if (take) begin
      mask <= mask & (mask - NUM_BUTTONS'(1));  // drop lowest set bit
    end
  end

  always_ff @(posedge clk) begin
    if (load) levels <= cur_levels;
  end

  `MBD_ASSERT_NOW(a_no_load_busy, load, !busy, "item loaded while reports pending")
  `MBD_ASSERT_NEXT(a_last_empties, take && out_last, mask == '0,
                   "reports left after last report")
  `MBD_ASSERT_NEXT(a_one_per_take, take && !out_last,
                   $countones(mask) == $countones($past(mask)) - 1,
                   "report take did not drop exactly one")

endmodule

// File: hdl/multi_button_debouncer_core.sv
// ----------------------------------------------------------------------------
// multi_button_debouncer_core
// Lockout-timer debouncer for a row of buttons with ordered change reports.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item: operation (tick, pin edge on button_id, or poll)
//   and the raw pin levels. rpt carries one report per changed button in
//   ascending button order; last_report marks the final one of an item.
//   cfg_write/cfg_index/cfg_data write debounce_ticks (0) or invert_mask (1).
// Timing:
//   An item's reports appear from the cycle after it is taken, one per
//   cycle while rpt.ready is high. cmd.ready stays low until the last
//   report is taken; the report queue in the merge stage holds it low.
// Stall:
//   A low rpt.ready holds the current report and all after it; nothing is
//   lost. An item that causes no report leaves cmd.ready high.
// Reset:
//   rst (synchronous) clears all countdowns, all stable levels to released
//   and the report queue; registers return to 250 ticks and mask 63.
// ----------------------------------------------------------------------------
module multi_button_debouncer_core #(
  parameter int NUM_BUTTONS = 7,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  mbd_cmd_if.sink                       cmd,
  mbd_rpt_if.source                     rpt,
  input  logic                          cfg_write,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::TICKS_W-1:0]   cfg_data
);
  import mbd_pkg::*;

  // configuration registers
  logic [TICKS_W-1:0] debounce_ticks;
  logic [MASK_W-1:0]  invert_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= TICKS_RESET;
      invert_mask    <= INVERT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks <= cfg_data;
        CFG_INVERT:   invert_mask    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // countdown load value, saturated to the counter range
  logic [31:0]            ticks_wide;
  logic [31:0]            count_max;
  logic [COUNT_WIDTH-1:0] load_value;

  assign ticks_wide = 32'(debounce_ticks);
  assign count_max  = 32'({COUNT_WIDTH{1'b1}});
  assign load_value = (ticks_wide > count_max) ? {COUNT_WIDTH{1'b1}}
                                               : ticks_wide[COUNT_WIDTH-1:0];

  // one item at a time: ready only with an empty report queue
  logic busy;
  logic accept;

  assign cmd.ready = !busy;
  assign accept    = cmd.valid && cmd.ready;

  // pin levels after inversion; buttons past the pin field read zero
  logic [PIN_W-1:0] pin_level;
  assign pin_level = cmd.pin_levels ^ invert_mask;

  lane_cmd_t [NUM_BUTTONS-1:0] lane_cmd;
  lane_rpt_t [NUM_BUTTONS-1:0] lane_rpt;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    logic level;
    if (g < PIN_W) begin : g_pin
      assign level = pin_level[g];
    end else begin : g_nopin
      assign level = 1'b0;
    end

    assign lane_cmd[g].accept = accept;
    assign lane_cmd[g].op     = cmd.operation;
    assign lane_cmd[g].hit    = (32'(cmd.button_id) == g);

    mbd_lane #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .cmd        (lane_cmd[g]),
      .level      (level),
      .load_value (load_value),
      .rpt        (lane_rpt[g])
    );
  end

  // ordered report queue
  mbd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .rpt        (lane_rpt),
    .busy       (busy),
    .out_valid  (rpt.valid),
    .out_ready  (rpt.ready),
    .out_button (rpt.report_button),
    .out_level  (rpt.report_level),
    .out_last   (rpt.last_report)
  );

endmodule
